### rtl/core/servo_stall_detector_top_assert.svh
// ----------------------------------------------------------------------------
// Servo stall detector assertion macros
// Concurrent assertion wrappers shared by the stall detector RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_STALL_DETECTOR_TOP_ASSERT_SVH
`define SERVO_STALL_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and active-low reset
`define SSD_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Assertion on the block clock and reset
`define SSD_ASSERT(lbl, prop, msg) \
  `SSD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`else

`define SSD_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg)
`define SSD_ASSERT(lbl, prop, msg)

`endif

`endif

### rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Servo stall detector package
// Shared types, register indexes and defaults for the stall detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Pitch limit bounds in 1/16 degree
  localparam int PITCH_MIN_SIXTEENTHS = 48;
  localparam int PITCH_MAX_SIXTEENTHS = 1392;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_ENABLE      = 3'd0,
    REG_CHECK_INTERVAL_MS = 3'd1,
    REG_MIN_TARGET_DELTA  = 3'd2,
    REG_MAX_STUCK_DELTA   = 3'd3,
    REG_CURRENT_THRESHOLD = 3'd4,
    REG_LOAD_THRESHOLD    = 3'd5,
    REG_CONFIRM_HITS      = 3'd6,
    REG_ZERO_POSITION_RAW = 3'd7
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic        stall_enable;
    logic [15:0] check_interval_ms;
    logic [9:0]  min_target_delta;
    logic [9:0]  max_stuck_delta;
    logic [11:0] current_threshold;
    logic [9:0]  load_threshold;
    logic [7:0]  confirm_hits;
    logic [9:0]  zero_position_raw;
  } cfg_t;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic        load_ok;
    logic [9:0]  load_reading;
    logic        current_ok;
    logic [11:0] current_reading;
    logic        position_ok;
    logic [9:0]  position_reading;
    logic [9:0]  target_position;
    logic [31:0] now_ms;
  } item_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic signed [13:0] pitch_limit;
    logic [9:0]         hold_position;
    logic               stall_confirmed;
    logic               sampled;
  } result_t;

  // Tracking state carried from item to item
  typedef struct packed {
    logic [31:0]        last_check_time;
    logic [9:0]         last_sample_position;
    logic               last_direction_up;
    logic               last_sample_valid;
    logic [7:0]         hit_count;
    logic signed [13:0] limit_sixteenths;
  } track_t;

endpackage

### rtl/core/ssd_cfg.sv
// ----------------------------------------------------------------------------
// Stall detector configuration registers
// Holds the eight configuration registers behind a plain write port.
// ----------------------------------------------------------------------------
module ssd_cfg
  import ssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg = cfg_r;

  // Load defaults on reset, update the addressed register on a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_enable      <= 1'b1;
      cfg_r.check_interval_ms <= 16'd100;
      cfg_r.min_target_delta  <= 10'd10;
      cfg_r.max_stuck_delta   <= 10'd2;
      cfg_r.current_threshold <= 12'd500;
      cfg_r.load_threshold    <= 10'd600;
      cfg_r.confirm_hits      <= 8'd3;
      cfg_r.zero_position_raw <= 10'd512;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STALL_ENABLE:      cfg_r.stall_enable      <= cfg_wdata[0];
        REG_CHECK_INTERVAL_MS: cfg_r.check_interval_ms <= cfg_wdata[15:0];
        REG_MIN_TARGET_DELTA:  cfg_r.min_target_delta  <= cfg_wdata[9:0];
        REG_MAX_STUCK_DELTA:   cfg_r.max_stuck_delta   <= cfg_wdata[9:0];
        REG_CURRENT_THRESHOLD: cfg_r.current_threshold <= cfg_wdata[11:0];
        REG_LOAD_THRESHOLD:    cfg_r.load_threshold    <= cfg_wdata[9:0];
        REG_CONFIRM_HITS:      cfg_r.confirm_hits      <= cfg_wdata[7:0];
        REG_ZERO_POSITION_RAW: cfg_r.zero_position_raw <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/ssd_eval.sv
// ----------------------------------------------------------------------------
// Stall detector evaluation
// Combinational step: gates one word, classifies the sample and works out
// the next tracking state and the result.
// ----------------------------------------------------------------------------
module ssd_eval
  import ssd_pkg::*;
#(
  parameter int PITCH_MIN = PITCH_MIN_SIXTEENTHS
)
(
  input  cfg_t    cfg,
  input  track_t  trk,
  input  item_t   item,
  output track_t  trk_nxt,
  output result_t res
);

  // Angle must exceed this before the limit may tighten
  localparam logic signed [14:0] ANGLE_FLOOR = 15'(PITCH_MIN + 80);
  localparam logic signed [14:0] LIMIT_BACKOFF = 15'sd32;

  logic [31:0]        elapsed;
  logic               pass_gate;
  logic signed [10:0] tdelta;
  logic [10:0]        tabs;
  logic               far;
  logic               up;
  logic               same_dir;
  logic signed [10:0] pdelta;
  logic [10:0]        pabs;
  logic               stuck;
  logic               spike;
  logic [7:0]         hits_inc;
  logic [7:0]         hits_upd;
  logic signed [10:0] zdiff;
  logic signed [14:0] zext;
  logic signed [14:0] angle;
  logic signed [14:0] cand;
  logic               tighten;

  // Interval gate on wrapping time
  assign elapsed   = item.now_ms - trk.last_check_time;
  assign pass_gate = cfg.stall_enable && (elapsed >= {16'd0, cfg.check_interval_ms});

  // Target distance and demanded direction
  assign tdelta = $signed({1'b0, item.target_position}) - $signed({1'b0, item.position_reading});
  assign tabs   = tdelta[10] ? 11'(-tdelta) : 11'(tdelta);
  assign far    = tabs >= {1'b0, cfg.min_target_delta};
  assign up     = !tdelta[10] && (tdelta != 11'sd0);
  assign same_dir = trk.last_sample_valid && (up == trk.last_direction_up);

  // Stuck and spike tests
  assign pdelta = $signed({1'b0, item.position_reading})
                - $signed({1'b0, trk.last_sample_position});
  assign pabs   = pdelta[10] ? 11'(-pdelta) : 11'(pdelta);
  assign stuck  = pabs <= {1'b0, cfg.max_stuck_delta};
  assign spike  = (item.current_reading >= cfg.current_threshold)
               || (item.load_reading >= cfg.load_threshold);

  // Saturating hit count
  assign hits_inc = (trk.hit_count == 8'hFF) ? trk.hit_count : trk.hit_count + 8'd1;
  always_comb begin
    if (!same_dir) begin
      hits_upd = 8'd0;
    end else if (stuck && spike) begin
      hits_upd = hits_inc;
    end else if (!stuck) begin
      hits_upd = 8'd0;
    end else begin
      hits_upd = trk.hit_count;
    end
  end

  // Angle in 1/16 degree: times five as shift and add
  assign zdiff   = $signed({1'b0, item.position_reading})
                 - $signed({1'b0, cfg.zero_position_raw});
  assign zext    = 15'(zdiff);
  assign angle   = (zext <<< 2) + zext;
  assign cand    = angle - LIMIT_BACKOFF;
  assign tighten = (angle > ANGLE_FLOOR) && (cand < 15'(trk.limit_sixteenths));

  // Next state and result
  always_comb begin
    trk_nxt = trk;
    res     = '0;
    res.pitch_limit = trk.limit_sixteenths;
    if (pass_gate) begin
      trk_nxt.last_check_time = item.now_ms;
      res.sampled = 1'b1;
      if (!item.position_ok || !far ||
          (same_dir && (!item.current_ok || !item.load_ok))) begin
        // Bad read or target reached: drop tracking
        trk_nxt.last_sample_valid = 1'b0;
        trk_nxt.last_direction_up = 1'b0;
        trk_nxt.hit_count         = 8'd0;
      end else if (hits_upd >= cfg.confirm_hits) begin
        // Stall confirmed: hold, maybe tighten, then drop tracking
        trk_nxt.last_sample_position = item.position_reading;
        trk_nxt.last_sample_valid    = 1'b0;
        trk_nxt.last_direction_up    = 1'b0;
        trk_nxt.hit_count            = 8'd0;
        if (tighten) begin
          trk_nxt.limit_sixteenths = cand[13:0];
        end
        res.stall_confirmed = 1'b1;
        res.hold_position   = item.position_reading;
        res.pitch_limit     = tighten ? cand[13:0] : trk.limit_sixteenths;
      end else begin
        // Store the sample and keep counting
        trk_nxt.last_sample_position = item.position_reading;
        trk_nxt.last_direction_up    = up;
        trk_nxt.last_sample_valid    = 1'b1;
        trk_nxt.hit_count            = hits_upd;
      end
    end
  end

endmodule

### rtl/core/servo_stall_detector_top.sv
// ----------------------------------------------------------------------------
// Servo stall detector top level
// Stall guard for a pitch servo, one commanded move per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per commanded move (time stamp, target, feedback with
//            ok flags). A word is taken when in_tvalid and in_tready are high.
//   out_*  : exactly one result word per input word, in order: sampled flag,
//            stall confirmed, hold position and the current pitch limit.
//   cfg_*  : register writes, one per cycle with cfg_we high; write only
//            while no result is outstanding.
//   The result is registered in the cycle after the input word is taken.
//   Throughput: one word per cycle while out_tready is high; the tracking
//   state is updated by a single combinational step between the input port
//   and the result register; each word sees the state left by the one before.
//   Reset (synchronous, rst_n low) loads the register defaults, clears the
//   tracking and sets the pitch limit to its maximum.
//   Stall: while out_tready is low and a result waits, in_tready is low and
//   the held result stays put; in_tready rises in the same cycle that the
//   waiting result is taken.
// ----------------------------------------------------------------------------
`include "servo_stall_detector_top_assert.svh"

module servo_stall_detector_top
  import ssd_pkg::*;
#(
  parameter int PITCH_MIN = PITCH_MIN_SIXTEENTHS,
  parameter int PITCH_MAX = PITCH_MAX_SIXTEENTHS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // now_ms[31:0], target_position[41:32], position_reading[51:42],
  // position_ok[52], current_reading[64:53], current_ok[65],
  // load_reading[75:66], load_ok[76], unused [79:77]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sampled[0], stall_confirmed[1], hold_position[11:2],
  // pitch_limit[25:12], zero fill [31:26]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  track_t  trk_r;
  track_t  trk_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_acc;

  // Configuration registers
  ssd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Unpack the input word
  assign item = item_t'(in_tdata[$bits(item_t)-1:0]);

  // Evaluation step
  ssd_eval #(
    .PITCH_MIN (PITCH_MIN)
  ) u_eval (
    .cfg     (cfg),
    .trk     (trk_r),
    .item    (item),
    .trk_nxt (trk_nxt),
    .res     (res_nxt)
  );

  // Accept while the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Tracking state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r.last_check_time      <= '0;
      trk_r.last_sample_position <= '0;
      trk_r.last_direction_up    <= 1'b0;
      trk_r.last_sample_valid    <= 1'b0;
      trk_r.hit_count            <= '0;
      trk_r.limit_sixteenths     <= 14'(PITCH_MAX);
      out_valid_r                <= 1'b0;
    end else begin
      if (in_acc) begin
        trk_r       <= trk_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_r};

  // The pitch limit only ever tightens
  `SSD_ASSERT(a_limit_tightens,
    in_acc |=> (trk_r.limit_sixteenths <= $past(trk_r.limit_sixteenths)),
    "pitch limit loosened")

  // A confirmed stall is always a sampled word
  `SSD_ASSERT(a_confirm_sampled,
    (out_valid_r && res_r.stall_confirmed) |-> res_r.sampled,
    "stall confirmed on an unsampled word")

  // Tracking is dropped after a confirmed stall
  `SSD_ASSERT(a_clear_after_stall,
    (in_acc && res_nxt.stall_confirmed) |=>
      (!trk_r.last_sample_valid && (trk_r.hit_count == 8'd0)),
    "tracking kept after stall")

  // Disabled block leaves the sample time alone
  `SSD_ASSERT(a_disabled_idle,
    (in_acc && !cfg.stall_enable) |=> $stable(trk_r.last_check_time),
    "sample time moved while disabled")

endmodule
